/* rtl/bsim_pkg.sv */
// Package for the bank switch IRQ mapper: request types, address pages and codes.
`default_nettype none

package bsim_pkg;

    // Input request: one CPU cycle tick or one CPU write.
    typedef struct packed {
        logic        func;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
        logic [13:0] ppu_address;
    } t_in_req;

    // Result request: translated banks, mirroring and IRQ level.
    typedef struct packed {
        logic [1:0] prg_region;
        logic [7:0] prg_bank;
        logic [7:0] chr_bank;
        logic [1:0] mirror_mode;
        logic       irq_line;
    } t_out_req;

    // Request kinds.
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Write pages, taken from address bits 15:12.
    localparam logic [3:0] PAGE_PRG0 = 4'h8;
    localparam logic [3:0] PAGE_CTRL = 4'h9;
    localparam logic [3:0] PAGE_PRG1 = 4'hA;
    localparam logic [3:0] PAGE_CHR  = 4'hB;

    // Control registers within the 0x9000 page, taken from address bits 2:0.
    localparam logic [2:0] CTRL_SWAP      = 3'd0;
    localparam logic [2:0] CTRL_MIRROR    = 3'd1;
    localparam logic [2:0] CTRL_IRQ_EN    = 3'd3;
    localparam logic [2:0] CTRL_IRQ_LOAD  = 3'd4;
    localparam logic [2:0] CTRL_RELOAD_HI = 3'd5;
    localparam logic [2:0] CTRL_RELOAD_LO = 3'd6;

    // CPU address region codes.
    localparam logic [1:0] REGION_NONE = 2'd0;
    localparam logic [1:0] REGION_WRAM = 2'd1;
    localparam logic [1:0] REGION_ROM  = 2'd2;

    // Mirroring codes.
    localparam logic [1:0] MIRROR_VERT   = 2'd0;
    localparam logic [1:0] MIRROR_HORIZ  = 2'd1;
    localparam logic [1:0] MIRROR_SINGLE = 2'd2;

    // Fixed program banks: second last at 0xC000 (0x8000 in swap mode), last at 0xE000.
    localparam logic [7:0] BANK_SECOND_LAST = 8'hFE;
    localparam logic [7:0] BANK_LAST        = 8'hFF;

    // Region boundaries on CPU address bits 15:13.
    localparam logic [2:0] WRAM_TOP3 = 3'b011;

endpackage

`default_nettype wire

/* rtl/bank_switch_irq_mapper.sv */
// Bank switch mapper with a CPU cycle IRQ counter, one request per cycle while o_in_stall is low.
// A result is registered in the result register, or in the skid register while the result register is stalled.
// Throughput: one request per cycle while o_in_stall is low; state update and translation are one combinational pass.
// A two-entry output stage (result register plus skid register) lets a request
// be accepted while a result is still stalled; o_in_stall rises when both are full.
// Reset (synchronous, active low) restores the power-on banks and clears the IRQ logic.
`default_nettype none

module bank_switch_irq_mapper (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire bsim_pkg::t_in_req i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output bsim_pkg::t_out_req     o_out_res
);
    import bsim_pkg::*;

    // Mapper state.
    logic [7:0]  r_prg_bank [2];
    logic [7:0]  r_chr_bank [8];
    logic        r_prg_swap;
    logic [1:0]  r_mirror_bits;
    logic        r_irq_enabled;
    logic [15:0] r_irq_counter;
    logic [15:0] r_irq_reload;
    logic        r_irq_delay;
    logic        r_irq_pending;

    logic [7:0]  n_prg_bank [2];
    logic [7:0]  n_chr_bank [8];
    logic        n_prg_swap;
    logic [1:0]  n_mirror_bits;
    logic        n_irq_enabled;
    logic [15:0] n_irq_counter;
    logic [15:0] n_irq_reload;
    logic        n_irq_delay;
    logic        n_irq_pending;

    // Output stage.
    logic     r_out_valid;
    t_out_req r_out_res;
    logic     r_skid_valid;
    t_out_req r_skid_res;

    logic     in_accept;
    logic     out_take;
    t_out_req n_res;
    logic [3:0] wr_page;
    logic [2:0] wr_sel;
    logic [1:0] prg_slot;

    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    assign wr_page = i_in_req.cpu_address[15:12];
    assign wr_sel  = i_in_req.cpu_address[2:0];

    // Next state: either a counter tick or a register write.
    always_comb begin
        n_prg_bank    = r_prg_bank;
        n_chr_bank    = r_chr_bank;
        n_prg_swap    = r_prg_swap;
        n_mirror_bits = r_mirror_bits;
        n_irq_enabled = r_irq_enabled;
        n_irq_counter = r_irq_counter;
        n_irq_reload  = r_irq_reload;
        n_irq_delay   = r_irq_delay;
        n_irq_pending = r_irq_pending;
        if (i_in_req.func == FUNC_TICK) begin
            // The delayed IRQ asserts on the tick after the one on which the counter hits zero.
            if (r_irq_delay) begin
                n_irq_delay   = 1'b0;
                n_irq_pending = 1'b1;
            end
            if (r_irq_enabled && (r_irq_counter != 16'd0)) begin
                n_irq_counter = r_irq_counter - 16'd1;
                if (r_irq_counter == 16'd1) begin
                    n_irq_enabled = 1'b0;
                    n_irq_delay   = 1'b1;
                end
            end
        end else begin
            case (wr_page)
                PAGE_PRG0: n_prg_bank[0] = i_in_req.write_data;
                PAGE_PRG1: n_prg_bank[1] = i_in_req.write_data;
                PAGE_CHR:  n_chr_bank[wr_sel] = i_in_req.write_data;
                PAGE_CTRL: begin
                    case (wr_sel)
                        CTRL_SWAP:   n_prg_swap = i_in_req.write_data[7];
                        CTRL_MIRROR: n_mirror_bits = i_in_req.write_data[7:6];
                        CTRL_IRQ_EN: begin
                            n_irq_enabled = i_in_req.write_data[7];
                            n_irq_pending = 1'b0;
                        end
                        CTRL_IRQ_LOAD: begin
                            n_irq_counter = r_irq_reload;
                            n_irq_pending = 1'b0;
                        end
                        CTRL_RELOAD_HI: n_irq_reload[15:8] = i_in_req.write_data;
                        CTRL_RELOAD_LO: n_irq_reload[7:0]  = i_in_req.write_data;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Result from the state after the step.
    always_comb begin
        prg_slot = i_in_req.cpu_address[14:13];
        if (n_prg_swap && !prg_slot[0]) begin
            prg_slot[1] = ~prg_slot[1];
        end
        if (!i_in_req.cpu_address[15] && (i_in_req.cpu_address[15:13] < WRAM_TOP3)) begin
            n_res.prg_region = REGION_NONE;
            n_res.prg_bank   = 8'd0;
        end else if (!i_in_req.cpu_address[15]) begin
            n_res.prg_region = REGION_WRAM;
            n_res.prg_bank   = 8'd0;
        end else begin
            n_res.prg_region = REGION_ROM;
            case (prg_slot)
                2'd0:    n_res.prg_bank = n_prg_bank[0];
                2'd1:    n_res.prg_bank = n_prg_bank[1];
                2'd2:    n_res.prg_bank = BANK_SECOND_LAST;
                default: n_res.prg_bank = BANK_LAST;
            endcase
        end
        if (i_in_req.ppu_address[13]) begin
            n_res.chr_bank = 8'd0;
        end else begin
            n_res.chr_bank = n_chr_bank[i_in_req.ppu_address[12:10]];
        end
        case (n_mirror_bits)
            2'd0:    n_res.mirror_mode = MIRROR_VERT;
            2'd2:    n_res.mirror_mode = MIRROR_HORIZ;
            default: n_res.mirror_mode = MIRROR_SINGLE;
        endcase
        n_res.irq_line = n_irq_pending;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank[0] <= 8'd0;
            r_prg_bank[1] <= 8'd1;
            for (int i = 0; i < 8; i++) begin
                r_chr_bank[i] <= 8'(i);
            end
            r_prg_swap    <= 1'b0;
            r_mirror_bits <= 2'd0;
            r_irq_enabled <= 1'b0;
            r_irq_counter <= 16'd0;
            r_irq_reload  <= 16'd0;
            r_irq_delay   <= 1'b0;
            r_irq_pending <= 1'b0;
        end else if (in_accept) begin
            r_prg_bank    <= n_prg_bank;
            r_chr_bank    <= n_chr_bank;
            r_prg_swap    <= n_prg_swap;
            r_mirror_bits <= n_mirror_bits;
            r_irq_enabled <= n_irq_enabled;
            r_irq_counter <= n_irq_counter;
            r_irq_reload  <= n_irq_reload;
            r_irq_delay   <= n_irq_delay;
            r_irq_pending <= n_irq_pending;
        end
    end

    // Output register and skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload of the output stage.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_res <= r_skid_res;
            end else if (in_accept) begin
                r_out_res <= n_res;
            end
        end else if (in_accept) begin
            r_skid_res <= n_res;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_bank_switch_irq_mapper.sv */
// Self-checking testbench for the bank switch IRQ mapper: directed and random CPU bus cycles.
module tb_bank_switch_irq_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    import bsim_pkg::*;

    localparam int ITEM_TARGET  = 1900;
    localparam int DRAIN_CYCLES = 8;
    localparam int STUCK_LIMIT  = 2000;

    // Clock, reset and the two request channels.
    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_in_req  in_req   = '0;
    logic     out_stall = 1'b0;
    logic     in_stall;
    logic     out_valid;
    t_out_req out_res;

    bank_switch_irq_mapper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bus cycles waiting to be driven, and translations waiting to come back.
    t_in_req  bus_cycles_todo[$];
    t_out_req translations_due[$];

    int   total_cycles;
    int   n_accepted;
    int   n_ticks;
    int   n_writes;
    int   n_irq_high;
    int   fail_count;
    int   gap_left;
    int   run_left;
    logic quiet = 1'b0;

    // Shadow copy of the mapper state.
    logic [7:0]  prg_sel [2];
    logic [7:0]  chr_sel [8];
    logic        swap_q;
    logic [1:0]  mirror_q;
    logic        irq_en_q;
    logic [15:0] irq_count_q;
    logic [15:0] irq_reload_q;
    logic        irq_delay_q;
    logic        irq_pend_q;

    function automatic void reset_mapper_model();
        prg_sel[0] = 8'd0;
        prg_sel[1] = 8'd1;
        for (int i = 0; i < 8; i++) chr_sel[i] = 8'(i);
        swap_q       = 1'b0;
        mirror_q     = 2'd0;
        irq_en_q     = 1'b0;
        irq_count_q  = 16'd0;
        irq_reload_q = 16'd0;
        irq_delay_q  = 1'b0;
        irq_pend_q   = 1'b0;
    endfunction

    // Apply one bus cycle to the shadow state and return the translation it yields.
    function automatic t_out_req mapper_step(t_in_req req);
        t_out_req   res;
        logic [1:0] slot;
        res = '0;
        if (req.func == FUNC_WRITE) begin
            case (req.cpu_address[15:12])
                PAGE_PRG0: prg_sel[0] = req.write_data;
                PAGE_PRG1: prg_sel[1] = req.write_data;
                PAGE_CHR:  chr_sel[req.cpu_address[2:0]] = req.write_data;
                PAGE_CTRL: begin
                    case (req.cpu_address[2:0])
                        CTRL_SWAP:      swap_q = req.write_data[7];
                        CTRL_MIRROR:    mirror_q = req.write_data[7:6];
                        CTRL_IRQ_EN: begin
                            irq_en_q   = req.write_data[7];
                            irq_pend_q = 1'b0;
                        end
                        CTRL_IRQ_LOAD: begin
                            irq_count_q = irq_reload_q;
                            irq_pend_q  = 1'b0;
                        end
                        CTRL_RELOAD_HI: irq_reload_q[15:8] = req.write_data;
                        CTRL_RELOAD_LO: irq_reload_q[7:0]  = req.write_data;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end else begin
            // The line rises on the tick after the one on which the counter reached zero.
            if (irq_delay_q) begin
                irq_delay_q = 1'b0;
                irq_pend_q  = 1'b1;
            end
            if (irq_en_q && irq_count_q != 16'd0) begin
                irq_count_q = irq_count_q - 16'd1;
                if (irq_count_q == 16'd0) begin
                    irq_en_q    = 1'b0;
                    irq_delay_q = 1'b1;
                end
            end
        end

        // Program side translation.
        if (req.cpu_address[15:13] < WRAM_TOP3) begin
            res.prg_region = REGION_NONE;
        end else if (req.cpu_address[15:13] == WRAM_TOP3) begin
            res.prg_region = REGION_WRAM;
        end else begin
            res.prg_region = REGION_ROM;
            slot = req.cpu_address[14:13];
            // Swap mode exchanges the 0x8000 and 0xC000 windows.
            if (swap_q && !slot[0]) slot[1] = ~slot[1];
            case (slot)
                2'd0:    res.prg_bank = prg_sel[0];
                2'd1:    res.prg_bank = prg_sel[1];
                2'd2:    res.prg_bank = BANK_SECOND_LAST;
                default: res.prg_bank = BANK_LAST;
            endcase
        end

        // Pattern banks cover only the lower 8 KB of PPU space.
        if (!req.ppu_address[13]) res.chr_bank = chr_sel[req.ppu_address[12:10]];

        case (mirror_q)
            2'd0:    res.mirror_mode = MIRROR_VERT;
            2'd2:    res.mirror_mode = MIRROR_HORIZ;
            default: res.mirror_mode = MIRROR_SINGLE;
        endcase
        res.irq_line = irq_pend_q;
        return res;
    endfunction

    function automatic t_in_req bus_cycle(logic func, logic [15:0] addr, logic [7:0] data,
                                          logic [13:0] ppu);
        t_in_req req;
        req.func        = func;
        req.cpu_address = addr;
        req.write_data  = data;
        req.ppu_address = ppu;
        return req;
    endfunction

    function automatic t_in_req random_tick();
        return bus_cycle(FUNC_TICK, 16'($urandom), 8'($urandom), 14'($urandom));
    endfunction

    function automatic t_in_req ctrl_write(logic [2:0] sel, logic [7:0] data);
        return bus_cycle(FUNC_WRITE, {PAGE_CTRL, 9'($urandom), sel}, data, 14'($urandom));
    endfunction

    // Mostly short idle stretches, a few long ones, none while in a quiet spell.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Toggle between spells of random idling and spells at full rate.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
    end

    // Request driver: holds each request until accepted, then idles for a random gap.
    always @(posedge i_clk) begin : driver
        logic    next_valid;
        t_in_req next_req;
        next_valid = in_valid;
        next_req   = in_req;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            gap_left   = 0;
        end else begin
            if (in_valid && !in_stall) begin
                translations_due.push_back(mapper_step(in_req));
                n_accepted++;
                if (in_req.func == FUNC_WRITE) n_writes++;
                else n_ticks++;
                next_valid = 1'b0;
                gap_left   = idle_len();
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (bus_cycles_todo.size() > 0) begin
                    next_req   = bus_cycles_todo.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
        in_req   <= next_req;
    end

    // Result side back-pressure: alternate open and stalled stretches.
    always @(posedge i_clk) begin : receiver
        int stall_len;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            run_left = 0;
        end else if (run_left > 0) begin
            run_left--;
        end else if (out_stall) begin
            out_stall <= 1'b0;
            run_left = $urandom_range(0, 6);
        end else begin
            stall_len = idle_len();
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                run_left = stall_len - 1;
            end
        end
    end

    // Result monitor: compare each accepted result against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_out_req want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (translations_due.size() == 0) begin
                $error("result arrived with no request outstanding");
                fail_count++;
            end else begin
                want = translations_due.pop_front();
                check_field("prg_region", 8'(want.prg_region), 8'(out_res.prg_region));
                check_field("prg_bank", want.prg_bank, out_res.prg_bank);
                check_field("chr_bank", want.chr_bank, out_res.chr_bank);
                check_field("mirror_mode", 8'(want.mirror_mode), 8'(out_res.mirror_mode));
                check_field("irq_line", 8'(want.irq_line), 8'(out_res.irq_line));
                if (out_res.irq_line === 1'b1) n_irq_high++;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin : watchdog
        int stuck_cycles;
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles.", STUCK_LIMIT);
            $display("bank_switch_irq_mapper regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int kind;
        int n;
        reset_mapper_model();

        // Address extremes on both buses; tick data must be ignored.
        bus_cycles_todo.push_back(bus_cycle(FUNC_TICK, 16'h0000, 8'hFF, 14'h0000));
        bus_cycles_todo.push_back(bus_cycle(FUNC_TICK, 16'h5FFF, 8'h00, 14'h1FFF));
        bus_cycles_todo.push_back(bus_cycle(FUNC_TICK, 16'h6000, 8'hAA, 14'h2000));
        bus_cycles_todo.push_back(bus_cycle(FUNC_TICK, 16'h7FFF, 8'h55, 14'h3FFF));

        // Bank registers, then swap mode moving the 0x8000 window.
        bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE, {PAGE_PRG0, 12'h000}, 8'hFF, 14'h0400));
        bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE, {PAGE_PRG1, 12'h000}, 8'h5A, 14'h0800));
        bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE, {PAGE_CHR, 12'h007}, 8'h80, 14'h1C00));
        bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE, {PAGE_CTRL, 9'h000, CTRL_SWAP},
                                            8'h80, 14'h0000));
        bus_cycles_todo.push_back(bus_cycle(FUNC_TICK, 16'hC000, 8'h00, 14'h1000));
        bus_cycles_todo.push_back(bus_cycle(FUNC_TICK, 16'hFFFF, 8'h00, 14'h0C00));

        // Mirror bits 01, 10 and 11 (single, horizontal, single); vertical is the reset code.
        bus_cycles_todo.push_back(ctrl_write(CTRL_MIRROR, 8'h40));
        bus_cycles_todo.push_back(ctrl_write(CTRL_MIRROR, 8'h80));
        bus_cycles_todo.push_back(ctrl_write(CTRL_MIRROR, 8'hC0));

        // Unused control slots and an unmapped page leave the state alone.
        bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE, 16'h9002, 8'hFF, 14'h0000));
        bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE, 16'h9007, 8'hFF, 14'h0000));
        bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE, 16'hC123, 8'hFF, 14'h0000));

        // Count down from two, acknowledge while the delayed line is pending.
        bus_cycles_todo.push_back(ctrl_write(CTRL_RELOAD_HI, 8'h00));
        bus_cycles_todo.push_back(ctrl_write(CTRL_RELOAD_LO, 8'h02));
        bus_cycles_todo.push_back(ctrl_write(CTRL_IRQ_LOAD, 8'h00));
        bus_cycles_todo.push_back(ctrl_write(CTRL_IRQ_EN, 8'h80));
        bus_cycles_todo.push_back(random_tick());
        bus_cycles_todo.push_back(random_tick());
        bus_cycles_todo.push_back(ctrl_write(CTRL_IRQ_EN, 8'h00));
        bus_cycles_todo.push_back(random_tick());

        // An enabled counter that holds zero neither counts nor fires.
        bus_cycles_todo.push_back(ctrl_write(CTRL_RELOAD_LO, 8'h00));
        bus_cycles_todo.push_back(ctrl_write(CTRL_IRQ_LOAD, 8'h00));
        bus_cycles_todo.push_back(ctrl_write(CTRL_IRQ_EN, 8'h80));
        bus_cycles_todo.push_back(random_tick());

        // Random traffic, weighted toward armed counters that actually expire.
        while (bus_cycles_todo.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                bus_cycles_todo.push_back(ctrl_write(CTRL_RELOAD_HI,
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00));
                bus_cycles_todo.push_back(ctrl_write(CTRL_RELOAD_LO,
                    ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24))));
                bus_cycles_todo.push_back(ctrl_write(CTRL_IRQ_LOAD, 8'($urandom)));
                bus_cycles_todo.push_back(ctrl_write(CTRL_IRQ_EN,
                    {1'($urandom_range(0, 3) != 0), 7'($urandom)}));
                n = $urandom_range(0, 40);
                repeat (n) begin
                    if ($urandom_range(0, 19) == 0)
                        bus_cycles_todo.push_back(ctrl_write(
                            $urandom_range(0, 1) ? CTRL_IRQ_EN : CTRL_IRQ_LOAD, 8'($urandom)));
                    else
                        bus_cycles_todo.push_back(random_tick());
                end
            end else if (kind < 55) begin
                repeat ($urandom_range(1, 20)) bus_cycles_todo.push_back(random_tick());
            end else if (kind < 85) begin
                case ($urandom_range(0, 3))
                    0: bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE,
                           {PAGE_PRG0, 12'($urandom)}, 8'($urandom), 14'($urandom)));
                    1: bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE,
                           {PAGE_PRG1, 12'($urandom)}, 8'($urandom), 14'($urandom)));
                    2: bus_cycles_todo.push_back(bus_cycle(FUNC_WRITE,
                           {PAGE_CHR, 12'($urandom)}, 8'($urandom), 14'($urandom)));
                    default: bus_cycles_todo.push_back(ctrl_write(3'($urandom), 8'($urandom)));
                endcase
            end else begin
                bus_cycles_todo.push_back(bus_cycle(1'($urandom), 16'($urandom),
                                                    8'($urandom), 14'($urandom)));
            end
        end
        total_cycles = bus_cycles_todo.size();

        // Hold reset, then release it and let the driver run.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < total_cycles || translations_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Drove %0d CPU cycle ticks and %0d CPU writes through the mapper.",
                 n_ticks, n_writes);
        $display("%0d results carried the IRQ line high; %0d field mismatches seen.",
                 n_irq_high, fail_count);
        if (fail_count == 0)
            $display("bank_switch_irq_mapper regression: pass");
        else
            $display("bank_switch_irq_mapper regression: fail");
        $finish;
    end

endmodule
